### src/wpf_pkg.sv
// shared types and constants for the waypoint follower
// no dependencies
package wpf_pkg;

   localparam int CFG_IDX_BITS = 3;
   localparam logic [CFG_IDX_BITS-1:0] REG_PWM_GAIN = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_WP_COUNT = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_FWD_LIM  = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] REG_YAW_LIM  = 3'd5;

   localparam int PWM_BITS = 11;
   localparam logic [PWM_BITS-1:0] PWM_NEUTRAL = 11'd1500;
   localparam logic [PWM_BITS-1:0] PWM_MIN     = 11'd1100;
   localparam logic [PWM_BITS-1:0] PWM_MAX     = 11'd1900;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS = 4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_SETUP, ST_ROTATE, ST_SCALE, ST_CMD, ST_PWM, ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic read_wp;
      logic setup;
      logic rotate;
      logic scale;
      logic cmd;
      logic pwm;
      logic [STEP_BITS-1:0] step;
   } ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic is_load;
      logic is_done;
   } stat_type;

   // arctangent of 2^-i as a binary angle
   function automatic logic [15:0] atan_lut(input logic [STEP_BITS-1:0] i);
      logic [15:0] r;
      case (i)
         4'd0: r = 16'd8192;
         4'd1: r = 16'd4836;
         4'd2: r = 16'd2555;
         4'd3: r = 16'd1297;
         4'd4: r = 16'd651;
         4'd5: r = 16'd326;
         4'd6: r = 16'd163;
         4'd7: r = 16'd81;
         4'd8: r = 16'd41;
         4'd9: r = 16'd20;
         4'd10: r = 16'd10;
         4'd11: r = 16'd5;
         4'd12: r = 16'd3;
         4'd13: r = 16'd1;
         4'd14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

### src/wpf_ctrl.sv
// sequencing state machine for the waypoint follower
// depends on wpf_pkg
module wpf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   input  wpf_pkg::stat_type stat,
   output wpf_pkg::ctrl_type ctrl
);

   wpf_pkg::state_type state_ff, state_in;
   logic [wpf_pkg::STEP_BITS-1:0] step_ff, step_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpf_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ctrl      = '0;
      ctrl.step = step_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         wpf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in = wpf_pkg::ST_READ;
            end
         end
         wpf_pkg::ST_READ: begin
            if (stat.is_load) state_in = wpf_pkg::ST_IDLE;
            else begin
               ctrl.read_wp = 1'b1;
               state_in = stat.is_done ? wpf_pkg::ST_OUT : wpf_pkg::ST_SETUP;
            end
         end
         wpf_pkg::ST_SETUP: begin
            ctrl.setup = 1'b1;
            step_in = '0;
            state_in = wpf_pkg::ST_ROTATE;
         end
         wpf_pkg::ST_ROTATE: begin
            ctrl.rotate = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == wpf_pkg::STEP_BITS'(wpf_pkg::CORDIC_STEPS - 1))
               state_in = wpf_pkg::ST_SCALE;
         end
         wpf_pkg::ST_SCALE: begin
            ctrl.scale = 1'b1;
            state_in = wpf_pkg::ST_CMD;
         end
         wpf_pkg::ST_CMD: begin
            ctrl.cmd = 1'b1;
            state_in = wpf_pkg::ST_PWM;
         end
         wpf_pkg::ST_PWM: begin
            ctrl.pwm = 1'b1;
            state_in = wpf_pkg::ST_OUT;
         end
         wpf_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = wpf_pkg::ST_IDLE;
         end
         default: state_in = wpf_pkg::ST_IDLE;
      endcase
   end

   // a result is offered only after a pose request
   a_out_from_pwm: assert property (@(posedge clock) disable iff (reset)
      state_ff == wpf_pkg::ST_OUT && !$past(state_ff == wpf_pkg::ST_OUT) |->
      $past(state_ff == wpf_pkg::ST_PWM) || $past(state_ff == wpf_pkg::ST_READ))
      else $error("result without computation");
   // rotation always runs all steps
   a_rot_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == wpf_pkg::ST_SCALE |-> $past(step_ff) ==
      wpf_pkg::STEP_BITS'(wpf_pkg::CORDIC_STEPS - 1))
      else $error("short rotation");
   // no request taken while busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != wpf_pkg::ST_IDLE |-> req_stall)
      else $error("request taken while busy");

endmodule

### src/wpf_datapath.sv
// waypoint table, cordic, command and pulse arithmetic
// depends on wpf_pkg
module wpf_datapath #(
   parameter int TABLE_DEPTH = 512,
   parameter int POS_BITS    = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wpf_pkg::ctrl_type        ctrl,
   output wpf_pkg::stat_type        stat,
   input  logic                     req_mode,
   input  logic [8:0]               req_slot,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   input  logic signed [POS_BITS-1:0] req_pos_z,
   input  logic signed [15:0]       req_heading,
   input  logic [7:0]               pwm_gain,
   input  logic [9:0]               waypoint_count,
   input  logic [15:0]              arrive_radius,
   input  logic [9:0]               deadband,
   input  logic [9:0]               forward_limit,
   input  logic [9:0]               yaw_limit,
   output logic [10:0]              rsp_pwm_forward,
   output logic [10:0]              rsp_pwm_lateral,
   output logic [10:0]              rsp_pwm_depth,
   output logic [10:0]              rsp_pwm_yaw,
   output logic [9:0]               rsp_target_index,
   output logic                     rsp_done_res
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int EW = POS_BITS + 1;
   localparam int CW = EW + 8 + 2;
   localparam int WW = 3 * POS_BITS;

   logic [WW-1:0] mem [TABLE_DEPTH];
   logic [WW-1:0] rd_ff;
   logic mode_ff;
   logic [8:0] slot_ff;
   logic signed [POS_BITS-1:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] hd_ff;
   logic [9:0] ptr_ff;
   logic done_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [15:0] ang_ff;
   logic zero_ff;
   logic signed [EW-1:0] ez_ff;
   logic [CW+16:0] dprod_ff;
   logic [CW-8:0] dist_ff;
   logic signed [15:0] fwd_ff, yaw_ff;
   logic [10:0] pf_ff, pd_ff, py2_ff;

   logic [10:0] count;
   logic [AW:0] ptr_ext;
   logic in_range;

   assign count = (32'(waypoint_count) > 32'(TABLE_DEPTH)) ? 11'(TABLE_DEPTH)
                  : {1'b0, waypoint_count};
   assign stat.is_load = !mode_ff;
   assign stat.is_done = {1'b0, ptr_ff} >= count;
   assign ptr_ext  = (AW + 1)'(ptr_ff);
   assign in_range = (32'(ptr_ff) < 32'(TABLE_DEPTH));

   // request capture and table write
   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         mode_ff <= req_mode;
         slot_ff <= req_slot;
         px_ff <= req_pos_x; py_ff <= req_pos_y; pz_ff <= req_pos_z;
         hd_ff <= req_heading;
         if (!req_mode && (32'(req_slot) < 32'(TABLE_DEPTH)))
            mem[AW'(req_slot)] <= {req_pos_x, req_pos_y, req_pos_z};
      end
      rd_ff <= mem[ptr_ext[AW-1:0]];
   end

   // cordic setup and rotation
   logic signed [EW-1:0] ex, ey, ez;
   logic signed [CW-1:0] sx, sy, nx, ny;
   logic [15:0] atn;
   always_comb begin
      ex = EW'(signed'(rd_ff[WW-1 -: POS_BITS])) - EW'(px_ff);
      ey = EW'(signed'(rd_ff[2*POS_BITS-1 -: POS_BITS])) - EW'(py_ff);
      ez = EW'(signed'(rd_ff[POS_BITS-1:0])) - EW'(pz_ff);
      sx = cx_ff >>> ctrl.step;
      sy = cy_ff >>> ctrl.step;
      atn = wpf_pkg::atan_lut(ctrl.step);
      nx = cy_ff[CW-1] ? cx_ff - sy : cx_ff + sy;
      ny = cy_ff[CW-1] ? cy_ff + sx : cy_ff - sx;
   end

   always_ff @(posedge clock) begin
      if (ctrl.setup) begin
         ez_ff   <= ez;
         zero_ff <= (ex == '0) && (ey == '0);
         if (ex[EW-1]) begin
            cx_ff <= -(CW'(ex) <<< 8); cy_ff <= -(CW'(ey) <<< 8); ang_ff <= 16'h8000;
         end else begin
            cx_ff <= CW'(ex) <<< 8; cy_ff <= CW'(ey) <<< 8; ang_ff <= '0;
         end
      end else if (ctrl.rotate) begin
         cx_ff <= nx; cy_ff <= ny;
         ang_ff <= cy_ff[CW-1] ? ang_ff - atn : ang_ff + atn;
      end
      if (ctrl.scale) dprod_ff <= (CW+17)'(cx_ff) * (CW+17)'(17'd39797);
   end

   // commands
   logic [CW+16:0] dsum;
   logic [15:0] err;
   logic [CW-8:0] dist_m;
   logic [10:0] dsat;
   logic [31:0] fprod;
   logic signed [31:0] yprod, yq, fq;
   always_comb begin
      dsum = dprod_ff + (CW+17)'(24'h800000);
      dist_m = dsum[CW+16:24];
      err  = (zero_ff ? 16'd0 : ang_ff) - hd_ff;
      yprod = 32'(signed'(err)) * 32'sd5147 + 32'sd32768;
      yq = yprod >>> 16;
      // scale by 4/5 via reciprocal; large distances saturate above any forward limit
      dsat = (dist_m > (CW-7)'(2047)) ? 11'd2047 : dist_m[10:0];
      fprod = 32'({dsat, 2'b00}) * 32'd52429;
      fq = signed'(fprod >> 18);
   end

   always_ff @(posedge clock) begin
      if (ctrl.cmd) begin
         dist_ff <= dist_m;
         if (yq > signed'(32'(yaw_limit))) yaw_ff <= 16'(yaw_limit);
         else if (yq < -signed'(32'(yaw_limit))) yaw_ff <= -16'(yaw_limit);
         else yaw_ff <= 16'(yq);
         fwd_ff <= (fq > signed'(32'(forward_limit))) ? 16'(forward_limit) : 16'(fq);
      end
   end

   // pulse conversion with deadband
   function automatic logic [10:0] to_pwm(input logic signed [EW:0] v, input logic rev,
                                          input logic [9:0] db, input logic [7:0] g);
      logic signed [EW:0] m, w;
      logic signed [EW+20:0] p, q;
      logic [10:0] r;
      m = v[EW] ? -v : v;
      w = rev ? -v : v;
      p = (EW+21)'(w) * (EW+21)'(signed'({1'b0, 9'd400})) * (EW+21)'(signed'({1'b0, g}));
      q = (p >>> 18) + (EW+21)'(1500);
      if (m < (EW+1)'(signed'({1'b0, db}))) r = wpf_pkg::PWM_NEUTRAL;
      else if (q < (EW+21)'(1100)) r = wpf_pkg::PWM_MIN;
      else if (q > (EW+21)'(1900)) r = wpf_pkg::PWM_MAX;
      else r = q[10:0];
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (ctrl.pwm) begin
         pf_ff  <= to_pwm((EW+1)'(fwd_ff), 1'b0, deadband, pwm_gain);
         pd_ff  <= to_pwm((EW+1)'(ez_ff), 1'b0, deadband, pwm_gain);
         py2_ff <= to_pwm((EW+1)'(yaw_ff), 1'b1, deadband, pwm_gain);
      end
   end

   // pointer and done flag
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         if (ctrl.read_wp) done_ff <= stat.is_done;
         if (ctrl.cmd && (dist_m < (CW-7)'(arrive_radius))) ptr_ff <= ptr_ff + 1'b1;
      end
   end

   assign rsp_pwm_forward  = done_ff ? wpf_pkg::PWM_NEUTRAL : pf_ff;
   assign rsp_pwm_depth    = done_ff ? wpf_pkg::PWM_NEUTRAL : pd_ff;
   assign rsp_pwm_yaw      = done_ff ? wpf_pkg::PWM_NEUTRAL : py2_ff;
   assign rsp_pwm_lateral  = to_pwm('0, 1'b1, deadband, pwm_gain);
   assign rsp_target_index = ptr_ff;
   assign rsp_done_res     = done_ff;

   logic unused;
   assign unused = ^{slot_ff, in_range, dist_ff, dprod_ff[0]};

   // the pointer moves only during command evaluation
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      ptr_ff != $past(ptr_ff) |-> $past(ctrl.cmd))
      else $error("pointer moved unexpectedly");
   // the pointer moves by at most one
   a_ptr_inc: assert property (@(posedge clock) disable iff (reset)
      ptr_ff != $past(ptr_ff) |-> ptr_ff == $past(ptr_ff) + 10'd1)
      else $error("pointer jump");
   // the forward command stays within its clamp
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.cmd) |-> fwd_ff <= 16'(forward_limit) && !fwd_ff[15])
      else $error("forward clamp broken");

endmodule

### src/waypoint_follower_pwm.sv
// waypoint follower top level: a pose request passes through the read, setup, rotate,
// scale, command and pulse states, the rotate state driving the shared cordic rotator,
// before its pulse set is offered; no new request is taken until the last one is done
// a load request gives no result; a finished-target pose goes from read straight to output
// synchronous reset clears the pointer, the registers to defaults and the controller;
// the waypoint table is not cleared
module waypoint_follower_pwm #(
   parameter int TABLE_DEPTH = 512,
   parameter int POS_BITS    = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [8:0]               req_slot,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   input  logic signed [POS_BITS-1:0] req_pos_z,
   input  logic signed [15:0]       req_heading,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [10:0]              rsp_pwm_forward,
   output logic [10:0]              rsp_pwm_lateral,
   output logic [10:0]              rsp_pwm_depth,
   output logic [10:0]              rsp_pwm_yaw,
   output logic [9:0]               rsp_target_index,
   output logic                     rsp_done_res,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [wpf_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  logic [15:0]              csr_data
);
   wpf_pkg::ctrl_type ctrl;
   wpf_pkg::stat_type stat;
   logic [7:0] gain_ff;
   logic [9:0] count_ff, db_ff, fl_ff, yl_ff;
   logic [15:0] rad_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 8'd128; count_ff <= 10'd501; rad_ff <= 16'd819;
         db_ff <= 10'd102; fl_ff <= 10'd307; yl_ff <= 10'd819;
      end else if (csr_valid) begin
         case (csr_index)
            wpf_pkg::REG_PWM_GAIN: gain_ff  <= csr_data[7:0];
            wpf_pkg::REG_WP_COUNT: count_ff <= csr_data[9:0];
            wpf_pkg::REG_RADIUS:   rad_ff   <= csr_data;
            wpf_pkg::REG_DEADBAND: db_ff    <= csr_data[9:0];
            wpf_pkg::REG_FWD_LIM:  fl_ff    <= csr_data[9:0];
            wpf_pkg::REG_YAW_LIM:  yl_ff    <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   wpf_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_stall, .rsp_valid, .stat, .ctrl
   );

   wpf_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .POS_BITS(POS_BITS)) u_dp (
      .clock, .reset, .ctrl, .stat, .req_mode, .req_slot, .req_pos_x, .req_pos_y,
      .req_pos_z, .req_heading, .pwm_gain(gain_ff), .waypoint_count(count_ff),
      .arrive_radius(rad_ff), .deadband(db_ff), .forward_limit(fl_ff),
      .yaw_limit(yl_ff), .rsp_pwm_forward, .rsp_pwm_lateral, .rsp_pwm_depth,
      .rsp_pwm_yaw, .rsp_target_index, .rsp_done_res
   );

endmodule

### sim/wpf_checker.sv
// request/response checker for the waypoint follower: predicts each pulse set and compares
// depends on wpf_pkg for register indexes and pulse constants
module wpf_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_mode,
   input  logic [8:0]         req_slot,
   input  logic signed [19:0] req_pos_x,
   input  logic signed [19:0] req_pos_y,
   input  logic signed [19:0] req_pos_z,
   input  logic signed [15:0] req_heading,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [10:0]        rsp_pwm_forward,
   input  logic [10:0]        rsp_pwm_lateral,
   input  logic [10:0]        rsp_pwm_depth,
   input  logic [10:0]        rsp_pwm_yaw,
   input  logic [9:0]         rsp_target_index,
   input  logic               rsp_done_res,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [wpf_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 pending,
   output logic [9:0]         target_now
);

   typedef struct {
      logic [10:0] fwd;
      logic [10:0] lat;
      logic [10:0] dep;
      logic [10:0] yaw;
      logic [9:0]  idx;
      logic        done;
   } pulse_set_type;

   localparam int DEPTH = 512;

   longint wp_x [DEPTH];
   longint wp_y [DEPTH];
   longint wp_z [DEPTH];
   logic [9:0]  pointer;
   logic [7:0]  gain;
   logic [9:0]  count;
   logic [15:0] radius;
   logic [9:0]  dead;
   logic [9:0]  fwd_lim;
   logic [9:0]  yaw_lim;
   pulse_set_type pulse_queue[$];

   assign target_now = pointer;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // deadband, optional reversal, then scale to a pulse width
   function automatic logic [10:0] to_pulse(longint v, bit reverse);
      longint mag;
      mag = v < 0 ? -v : v;
      if (mag < longint'(dead)) return wpf_pkg::PWM_NEUTRAL;
      if (reverse) v = -v;
      return 11'(clip(1500 + ((v * 400 * longint'(gain)) >>> 18), 1100, 1900));
   endfunction

   // one pose tick: cordic bearing and distance, commands, pointer advance
   function automatic pulse_set_type pose_tick(longint px, longint py, longint pz,
                                               logic [15:0] hdg);
      int atan_step[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                            41, 20, 10, 5, 3, 1, 1, 0};
      pulse_set_type r;
      longint lim, ex, ey, ez, cx, cy, nx, ny, dist_m, fwd, yawc, err;
      int ang;
      logic [15:0] e16;
      lim = count > 10'd512 ? 512 : longint'(count);
      if (longint'(pointer) >= lim) begin
         r = '{wpf_pkg::PWM_NEUTRAL, wpf_pkg::PWM_NEUTRAL, wpf_pkg::PWM_NEUTRAL,
               wpf_pkg::PWM_NEUTRAL, pointer, 1'b1};
         return r;
      end
      ex = wp_x[pointer] - px;
      ey = wp_y[pointer] - py;
      ez = wp_z[pointer] - pz;
      cx = ex * 256;
      cy = ey * 256;
      ang = 0;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         ang = 32768;
      end
      for (int i = 0; i < 16; i++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            ang += atan_step[i];
         end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            ang -= atan_step[i];
         end
         cx = nx;
         cy = ny;
      end
      if (ex == 0 && ey == 0) ang = 0;
      dist_m = (cx * 39797 + (longint'(1) << 23)) >>> 24;
      e16 = ang[15:0] - hdg;
      err = longint'($signed(e16));
      yawc = clip((err * 5147 + 32768) >>> 16, -longint'(yaw_lim), longint'(yaw_lim));
      fwd = clip((dist_m * 4) / 5, 0, longint'(fwd_lim));
      if (dist_m < longint'(radius)) pointer = pointer + 10'd1;
      r.fwd  = to_pulse(fwd, 1'b0);
      r.lat  = to_pulse(0, 1'b1);
      r.dep  = to_pulse(ez, 1'b0);
      r.yaw  = to_pulse(yawc, 1'b1);
      r.idx  = pointer;
      r.done = 1'b0;
      return r;
   endfunction

   // predictor and scoreboard
   always @(posedge clock) begin
      pulse_set_type want;
      if (reset) begin
         pointer  = '0;
         gain     = 8'd128;
         count    = 10'd501;
         radius   = 16'd819;
         dead     = 10'd102;
         fwd_lim  = 10'd307;
         yaw_lim  = 10'd819;
         pulse_queue.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wpf_pkg::REG_PWM_GAIN: gain    = csr_data[7:0];
               wpf_pkg::REG_WP_COUNT: count   = csr_data[9:0];
               wpf_pkg::REG_RADIUS:   radius  = csr_data;
               wpf_pkg::REG_DEADBAND: dead    = csr_data[9:0];
               wpf_pkg::REG_FWD_LIM:  fwd_lim = csr_data[9:0];
               wpf_pkg::REG_YAW_LIM:  yaw_lim = csr_data[9:0];
               default: ;
            endcase
         end
         // accepted requests
         if (req_valid && !req_stall) begin
            if (!req_mode) begin
               wp_x[req_slot] = longint'(req_pos_x);
               wp_y[req_slot] = longint'(req_pos_y);
               wp_z[req_slot] = longint'(req_pos_z);
            end else begin
               pulse_queue = {pulse_queue, pose_tick(longint'(req_pos_x),
                              longint'(req_pos_y), longint'(req_pos_z), req_heading)};
            end
         end
         // accepted responses
         if (rsp_valid && !rsp_stall) begin
            if (pulse_queue.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = pulse_queue.pop_front();
               if (rsp_pwm_forward !== want.fwd) begin
                  $error("pwm_forward expected %0d got %0d", want.fwd, rsp_pwm_forward);
                  fail_count++;
               end
               if (rsp_pwm_lateral !== want.lat) begin
                  $error("pwm_lateral expected %0d got %0d", want.lat, rsp_pwm_lateral);
                  fail_count++;
               end
               if (rsp_pwm_depth !== want.dep) begin
                  $error("pwm_depth expected %0d got %0d", want.dep, rsp_pwm_depth);
                  fail_count++;
               end
               if (rsp_pwm_yaw !== want.yaw) begin
                  $error("pwm_yaw expected %0d got %0d", want.yaw, rsp_pwm_yaw);
                  fail_count++;
               end
               if (rsp_target_index !== want.idx) begin
                  $error("target_index expected %0d got %0d", want.idx, rsp_target_index);
                  fail_count++;
               end
               if (rsp_done_res !== want.done) begin
                  $error("done_res expected %0d got %0d", want.done, rsp_done_res);
                  fail_count++;
               end
            end
         end
      end
      pending = pulse_queue.size();
   end

endmodule

### sim/tb.sv
// stimulus and verdict for the waypoint follower: table fill, directed poses, random phases
// depends on wpf_pkg, waypoint_follower_pwm and wpf_checker
module tb;

   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE = 40;
   localparam longint PMAX = 524287;
   localparam longint PMIN = -524288;

   logic clock, reset;
   logic req_valid, req_stall, req_mode;
   logic [8:0] req_slot;
   logic signed [19:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [15:0] req_heading;
   logic rsp_valid, rsp_stall;
   logic [10:0] rsp_pwm_forward, rsp_pwm_lateral, rsp_pwm_depth, rsp_pwm_yaw;
   logic [9:0] rsp_target_index;
   logic rsp_done_res;
   logic csr_valid, csr_ready;
   logic [wpf_pkg::CFG_IDX_BITS-1:0] csr_index;
   logic [15:0] csr_data;
   int fail_count, pending;
   logic [9:0] target_now;

   longint shadow_x [512];
   longint shadow_y [512];
   longint shadow_z [512];
   longint cur_radius;
   bit idle_on;
   bit hold_req;
   int quiet;

   waypoint_follower_pwm dut (.*);
   wpf_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // response side stalls: random bursts, or one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("[waypoint_follower_pwm] ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic longint clamp_pos(longint v);
      return v < PMIN ? PMIN : (v > PMAX ? PMAX : v);
   endfunction

   // uniform position over the full signed range
   function automatic longint rand_pos();
      return longint'($urandom_range(0, 20'hFFFFF)) - 524288;
   endfunction

   // one request, called at a falling edge, returns at a falling edge
   task automatic send_req(bit mode, logic [8:0] slot, longint x, longint y, longint z,
                           logic [15:0] hdg);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_slot    <= slot;
      req_pos_x   <= 20'(x);
      req_pos_y   <= 20'(y);
      req_pos_z   <= 20'(z);
      req_heading <= hdg;
      if (!mode) begin
         shadow_x[slot] = x;
         shadow_y[slot] = y;
         shadow_z[slot] = z;
      end
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic load_wp(logic [8:0] slot, longint x, longint y, longint z);
      send_req(1'b0, slot, x, y, z, 16'($urandom));
   endtask

   task automatic pose(longint x, longint y, longint z, logic [15:0] hdg);
      send_req(1'b1, 9'($urandom), x, y, z, hdg);
   endtask

   // stop sending and let the block go idle
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [wpf_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == wpf_pkg::REG_RADIUS) cur_radius = longint'(value);
   endtask

   task automatic set_all(logic [15:0] g, logic [15:0] cnt, logic [15:0] rad,
                          logic [15:0] db, logic [15:0] fl, logic [15:0] yl);
      write_reg(wpf_pkg::REG_PWM_GAIN, g);
      write_reg(wpf_pkg::REG_WP_COUNT, cnt);
      write_reg(wpf_pkg::REG_RADIUS, rad);
      write_reg(wpf_pkg::REG_DEADBAND, db);
      write_reg(wpf_pkg::REG_FWD_LIM, fl);
      write_reg(wpf_pkg::REG_YAW_LIM, yl);
   endtask

   // mix of hits on the current target, near misses, far poses and reloads
   task automatic random_phase(int n, int hit_pct);
      int kind, k;
      longint r;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         k = target_now > 10'd511 ? 511 : int'(target_now);
         r = cur_radius + 1;
         if (kind < 12) begin
            load_wp(9'($urandom), rand_pos(), rand_pos(), rand_pos());
         end else if (kind < 12 + hit_pct) begin
            pose(shadow_x[k], shadow_y[k], shadow_z[k], 16'($urandom));
         end else if (kind < 30 + hit_pct) begin
            pose(clamp_pos(shadow_x[k] + $signed($urandom_range(0, 2 * r)) - r),
                 clamp_pos(shadow_y[k] + $signed($urandom_range(0, 2 * r)) - r),
                 clamp_pos(shadow_z[k] + $signed($urandom_range(0, 4000)) - 2000),
                 16'($urandom));
         end else begin
            pose(rand_pos(), rand_pos(), rand_pos(), 16'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_slot = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_heading = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1'b1;
      hold_req = 1'b0;
      cur_radius = 819;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // fill the whole table so no pose ever reads an empty slot
      load_wp(9'd0, 0, 0, 0);
      load_wp(9'd1, PMAX, PMAX, PMAX);
      load_wp(9'd2, PMIN, PMIN, PMIN);
      for (int s = 3; s < 512; s++)
         load_wp(9'(s), rand_pos(), rand_pos(), longint'($urandom_range(0, 4000)) - 2000);

      // directed: axis bearings, extremes, zero error with a half turn of heading
      pose(PMAX, PMAX, PMAX, 16'h0000);
      pose(PMIN, PMIN, PMIN, 16'h8000);
      pose(-1000, 0, 0, 16'h7FFF);
      pose(0, -1000, 50, 16'h4000);
      pose(1000, 0, -50, 16'hC000);
      pose(0, 1000, 200, 16'h0001);
      pose(0, 0, 0, 16'h8000);
      pose(PMIN, PMIN, PMIN, 16'h2000);
      pose(PMAX, PMAX, PMAX, 16'h0000);
      pose(PMAX, PMAX, PMAX, 16'hFFFF);
      drain();

      // count zero makes every tick done
      write_reg(wpf_pkg::REG_WP_COUNT, 16'd0);
      pose(0, 0, 0, 16'h0000);
      pose(PMIN, PMAX, 0, 16'h1234);
      drain();
      write_reg(3'd6, 16'hFFFF);
      write_reg(3'd7, 16'h0000);
      write_reg(wpf_pkg::REG_WP_COUNT, 16'd512);

      random_phase(150, 8);
      drain();

      // largest gain and limits, no deadband, no arrivals; long output hold midway
      set_all(16'hFFFF, 16'd1023, 16'd0, 16'd0, 16'd1023, 16'd1023);
      random_phase(120, 8);
      hold_req = 1'b1;
      random_phase(180, 8);
      drain();

      // zero gain and limits, widest deadband and radius, random count
      set_all(16'd0, 16'($urandom_range(1, 512)), 16'hFFFF, 16'd1023, 16'd0, 16'd0);
      random_phase(180, 8);
      drain();

      set_all(16'($urandom), 16'($urandom_range(0, 1023)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 300)), 16'($urandom_range(0, 1023)),
              16'($urandom_range(0, 1023)));
      random_phase(200, 8);
      drain();

      // sweep to the end of the table with no idling
      set_all(16'd128, 16'd512, 16'd3000, 16'd102, 16'd307, 16'd819);
      idle_on = 1'b0;
      random_phase(300, 40);
      drain();

      if (fail_count == 0) begin
         $display("[waypoint_follower_pwm] OK");
      end else begin
         $display("[waypoint_follower_pwm] ERROR");
      end
      $finish;
   end

endmodule
